/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; each macro expects clk in scope, ASSERT_CLK also rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/grs_pkg.sv */
// shared constants, types and control structs for group_reverse_stream
// no dependencies
package grs_pkg;

  localparam int MAX_GROUP = 16;
  localparam int VAL_W     = 32;
  localparam int SIZE_W    = 5;
  localparam int ADDR_W    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [SIZE_W-1:0]       size_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // controller to datapath
  typedef struct packed {
    logic wr;    // store incoming request
    logic rd;    // issue one group memory read
    logic load;  // move read data into result register
  } grs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic flush;    // incoming request closes the group
    logic rd_more;  // reads still owed for current group
  } grs_sts_t;

endpackage

/* sv/grs_ifs.sv */
// channel interfaces for group_reverse_stream: input, result, configuration
// depends on grs_pkg
interface grs_in_if;
  import grs_pkg::*;
  logic valid;
  logic ready;
  val_t value;
  logic is_final;
  modport source(output valid, value, is_final, input ready);
  modport sink(input valid, value, is_final, output ready);
endinterface

interface grs_out_if;
  import grs_pkg::*;
  logic valid;
  logic ready;
  val_t value_res;
  logic run_last;
  logic list_last;
  modport source(output valid, value_res, run_last, list_last, input ready);
  modport sink(input valid, value_res, run_last, list_last, output ready);
endinterface

interface grs_cfg_if;
  import grs_pkg::*;
  logic  valid;
  logic  ready;
  size_t group_size;
  modport source(output valid, group_size, input ready);
  modport sink(input valid, group_size, output ready);
endinterface

/* sv/grs_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/grs_ctrl.sv */
// controller for group_reverse_stream: fill/drain sequencing and result handshake
// depends on grs_pkg
module grs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  grs_pkg::grs_sts_t  sts,
  output grs_pkg::grs_cmd_t  cmd
);
  import grs_pkg::*;

  typedef enum logic {ST_FILL, ST_DRAIN} state_t;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;
  logic   oval_r, oval_nxt;
  logic   load, issue, wr;

  assign in_ready  = (state_r == ST_FILL);
  assign out_valid = oval_r;

  assign wr    = (state_r == ST_FILL) && in_valid;
  assign load  = pend_r && (!oval_r || out_ready);
  assign issue = (state_r == ST_DRAIN) && sts.rd_more && (!pend_r || load);

  assign cmd.wr   = wr;
  assign cmd.rd   = issue;
  assign cmd.load = load;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (wr && sts.flush) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.rd_more && (!pend_r || load)) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase

    if (issue) begin
      pend_nxt = 1'b1;
    end else if (load) begin
      pend_nxt = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end

    if (load) begin
      oval_nxt = 1'b1;
    end else if (out_ready) begin
      oval_nxt = 1'b0;
    end else begin
      oval_nxt = oval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      pend_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule

/* sv/grs_dp.sv */
// datapath for group_reverse_stream: size register, fill count, group memory,
// read-back counter and result register; depends on grs_pkg and grs_ram
module grs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  grs_pkg::grs_cmd_t  cmd,
  output grs_pkg::grs_sts_t  sts,
  input  logic               cfg_we,
  input  grs_pkg::size_t     cfg_size,
  input  grs_pkg::val_t      in_value,
  input  logic               in_is_final,
  output grs_pkg::val_t      out_value_res,
  output logic               out_run_last,
  output logic               out_list_last
);
  import grs_pkg::*;

  size_t size_r;
  cnt_t  size_eff;
  addr_t fill_r;
  cnt_t  n_fill;
  cnt_t  rd_cnt_r;
  addr_t rd_addr;
  logic  fin_r;
  logic  pend_last_r;
  logic [VAL_W-1:0] ram_rdata;
  val_t  res_val_r;
  logic  res_run_r;
  logic  res_list_r;

  // clamp group size to 1..MAX_GROUP
  always_comb begin
    if (size_r == '0) begin
      size_eff = cnt_t'(1);
    end else if (int'(size_r) > MAX_GROUP) begin
      size_eff = cnt_t'(MAX_GROUP);
    end else begin
      size_eff = cnt_t'(size_r);
    end
  end

  assign n_fill      = cnt_t'(fill_r) + cnt_t'(1);
  assign sts.flush   = (n_fill >= size_eff) || in_is_final;
  assign sts.rd_more = (rd_cnt_r != '0);
  assign rd_addr     = addr_t'(rd_cnt_r - cnt_t'(1));

  grs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_GROUP)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (fill_r),
    .wdata (in_value),
    .re    (cmd.rd),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= size_t'(1);
      fill_r   <= '0;
      rd_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_size;
      end
      if (cmd.wr) begin
        if (sts.flush) begin
          fill_r   <= '0;
          rd_cnt_r <= n_fill;
        end else begin
          fill_r <= addr_t'(n_fill);
        end
      end else if (cmd.rd) begin
        rd_cnt_r <= rd_cnt_r - cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && sts.flush) begin
      fin_r <= in_is_final;
    end
    if (cmd.rd) begin
      pend_last_r <= (rd_cnt_r == cnt_t'(1));
    end
    if (cmd.load) begin
      res_val_r  <= $signed(ram_rdata);
      res_run_r  <= pend_last_r;
      res_list_r <= pend_last_r && fin_r;
    end
  end

  assign out_value_res = res_val_r;
  assign out_run_last  = res_run_r;
  assign out_list_last = res_list_r;

endmodule

/* sv/group_reverse_stream.sv */
// Group reversal stream: values are written into a 16-entry group memory
// until the group reaches the configured size (0 acts as 1, above 16 acts
// as 16) or a request flagged final arrives. The group of n values is then
// read back newest first at one read per cycle while the result is not
// stalled, through the registered memory port and a single result register;
// input requests are held off from the closing request until the last read
// lands. run_last marks the last result of a group, list_last that of a final
// group. group_size must be written only while the block is idle; the block
// itself does not enforce this. Depends on grs_pkg, grs_ifs, grs_ctrl,
// grs_dp and grs_ram.
module group_reverse_stream (
  input  logic      clk,
  input  logic      rst_n,
  grs_in_if.sink    in_ch,
  grs_out_if.source out_ch,
  grs_cfg_if.sink   cfg_ch
);
  import grs_pkg::*;

  grs_cmd_t cmd;
  grs_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  grs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid),
    .cfg_size      (cfg_ch.group_size),
    .in_value      (in_ch.value),
    .in_is_final   (in_ch.is_final),
    .out_value_res (out_ch.value_res),
    .out_run_last  (out_ch.run_last),
    .out_list_last (out_ch.list_last)
  );

endmodule

/* sv/grs_checker.sv */
// port-level checks for group_reverse_stream, attached by bind
// depends on grs_pkg and assert_macros.svh
`include "assert_macros.svh"

module grs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          in_is_final,
  input logic          out_valid,
  input logic          out_ready,
  input grs_pkg::val_t out_value_res,
  input logic          out_run_last,
  input logic          out_list_last
);
  import grs_pkg::*;

  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_value_res), "result dropped or changed while stalled")
  `ASSERT_CLK(a_list_in_run, out_valid && out_list_last |-> out_run_last, "list end without group end")
  `ASSERT_CLK(a_final_drains, in_valid && in_ready && in_is_final |=> !in_ready, "final request did not close the group")
  `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_is_final   (in_ch.is_final),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_value_res (out_ch.value_res),
  .out_run_last  (out_ch.run_last),
  .out_list_last (out_ch.list_last)
);

/* sim/tb.sv */
// self-checking testbench for group_reverse_stream: lists of signed values go in,
// reversed groups come out and are checked against an in-bench group predictor
// depends on grs_pkg, grs_ifs and the group_reverse_stream rtl
module tb;
  import grs_pkg::*;

  typedef struct {
    val_t value;
    logic is_final;
  } list_item_t;

  typedef struct {
    val_t value_res;
    logic run_last;
    logic list_last;
  } group_result_t;

  logic clk;
  logic rst_n;

  grs_in_if  in_ch();
  grs_out_if out_ch();
  grs_cfg_if cfg_ch();

  group_reverse_stream DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  list_item_t    list_items[$];
  group_result_t due_results[$];

  val_t  held_values[MAX_GROUP];
  int    held_count;
  size_t group_size_q;
  int    accepted_count;
  int    errors = 0;
  logic  calm;

  assign calm = (accepted_count >= 50) && (accepted_count < 80);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 300000);
    $display("tb failed");
    $finish;
  end

  function automatic val_t pick_value();
    case ($urandom_range(0, 5))
      0: return val_t'(32'h8000_0000);
      1: return val_t'(32'h7fff_ffff);
      2: return '0;
      3: return '1;
      default: return val_t'($urandom);
    endcase
  endfunction

  // input request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.value    <= '0;
      in_ch.is_final <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (list_items.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
        in_ch.valid    <= 1'b1;
        in_ch.value    <= list_items[0].value;
        in_ch.is_final <= list_items[0].is_final;
        void'(list_items.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predictor and result checker
  always @(posedge clk) begin
    int            eff;
    group_result_t got;
    group_result_t want;
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      held_count     = 0;
      group_size_q   = size_t'(1);
      accepted_count <= 0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
      if (cfg_ch.valid && cfg_ch.ready) begin
        group_size_q = cfg_ch.group_size;
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted_count <= accepted_count + 1;
        eff = int'(group_size_q);
        if (eff < 1) eff = 1;
        if (eff > MAX_GROUP) eff = MAX_GROUP;
        if (held_count >= MAX_GROUP) held_count = MAX_GROUP - 1;
        held_values[held_count] = in_ch.value;
        held_count++;
        if (held_count >= eff || in_ch.is_final) begin
          for (int k = 0; k < held_count; k++) begin
            want.value_res = held_values[held_count - 1 - k];
            want.run_last  = (k == held_count - 1);
            want.list_last = (k == held_count - 1) && in_ch.is_final;
            due_results.push_back(want);
          end
          held_count = 0;
        end
      end
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        got.value_res = out_ch.value_res;
        got.run_last  = out_ch.run_last;
        got.list_last = out_ch.list_last;
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual value %0d", $time,
                   got.value_res);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got.value_res !== want.value_res) begin
            $display("%0t value_res mismatch: expected %0d actual %0d", $time,
                     want.value_res, got.value_res);
            errors++;
          end
          if (got.run_last !== want.run_last) begin
            $display("%0t run_last mismatch: expected %0b actual %0b", $time,
                     want.run_last, got.run_last);
            errors++;
          end
          if (got.list_last !== want.list_last) begin
            $display("%0t list_last mismatch: expected %0b actual %0b", $time,
                     want.list_last, got.list_last);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (list_items.size() != 0 || in_ch.valid || due_results.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_group_size(input size_t s);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.group_size <= s;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input val_t v, input logic fin);
    list_item_t it;
    it.value    = v;
    it.is_final = fin;
    list_items.push_back(it);
  endtask

  initial begin
    int    sent;
    int    eff;
    int    len;
    int    lists;
    logic  broken;
    size_t s;
    rst_n          = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.group_size = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size of one, extreme values
    send_item(val_t'(32'h8000_0000), 1'b0);
    send_item(val_t'(32'h7fff_ffff), 1'b1);
    wait_idle();

    // final request that fills a group, then a short final group
    set_group_size(size_t'(3));
    send_item(val_t'(0), 1'b0);
    send_item(val_t'(-1), 1'b0);
    send_item(val_t'(32'h5555_aaaa), 1'b1);
    send_item(val_t'(32'haaaa_5555), 1'b1);
    wait_idle();

    // zero size acts as one
    set_group_size(size_t'(0));
    send_item(val_t'(12345), 1'b0);
    wait_idle();

    // size lowered under a partly filled group
    set_group_size(size_t'(8));
    for (int i = 0; i < 5; i++) send_item(pick_value(), 1'b0);
    wait_idle();
    set_group_size(size_t'(2));
    send_item(pick_value(), 1'b0);
    wait_idle();

    sent = 0;
    while (sent < 100) begin
      case ($urandom_range(0, 5))
        0: s = size_t'(0);
        1: s = size_t'(16);
        2: s = size_t'(31);
        3: s = size_t'(17);
        default: s = size_t'($urandom_range(1, 8));
      endcase
      set_group_size(s);
      eff = (s < 1) ? 1 : ((s > MAX_GROUP) ? MAX_GROUP : int'(s));
      lists = $urandom_range(1, 3);
      for (int l = 0; l < lists; l++) begin
        len = $urandom_range(1, 2 * eff + 1);
        if (len > 20) len = 20;
        if (len > 100 - sent) len = 100 - sent;
        broken = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++) begin
          send_item(pick_value(), (i == len - 1) && !broken);
        end
        sent += len;
      end
      // hold off until every result has drained
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* group_reverse_stream.f */
+incdir+sv
sv/grs_pkg.sv
sv/grs_ifs.sv
sv/grs_ram.sv
sv/grs_ctrl.sv
sv/grs_dp.sv
sv/group_reverse_stream.sv
sv/grs_checker.sv
sim/tb.sv
